@@ hdl/ecm_pkg.sv @@
// ----------------------------------------------------------------------------
// ecm_pkg
// Shared types and constants for the energy and charge meter.
// ----------------------------------------------------------------------------
package ecm_pkg;

  localparam int CHANNELS = 3;
  localparam int CH_W     = 2;

  localparam int ETHR_W   = 24;
  localparam int QTHR_W   = 16;
  localparam int CFG_W    = 24;
  localparam int CFG_A_W  = 1;

  localparam int VOLT_W   = 16;
  localparam int CUR_W    = 12;
  localparam int PWR_W    = 18;
  localparam int EACC_W   = 25;
  localparam int QACC_W   = 17;
  localparam int CNT_W    = 32;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 144;

  // floor(x/20) = (x * 52429) >> 20, exact for 16-bit x
  localparam logic [15:0] CUR_RECIP = 16'd52429;
  localparam int          CUR_SHIFT = 20;
  // floor(x/1000) = (x * 274877907) >> 38, exact for 28-bit x
  localparam logic [28:0] PWR_RECIP = 29'd274877907;
  localparam int          PWR_SHIFT = 38;

  localparam int MUL_A_W = 28;
  localparam int MUL_B_W = 29;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [ETHR_W-1:0] ETHR_RESET = 24'd360000;
  localparam logic [QTHR_W-1:0] QTHR_RESET = 16'd3600;

  localparam logic [CFG_A_W-1:0] REG_ENERGY_THR = 1'd0;
  localparam logic [CFG_A_W-1:0] REG_CHARGE_THR = 1'd1;

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_LOAD      = 2'd1,
    CMD_CLR_CHAN  = 2'd2,
    CMD_CLR_TOTAL = 2'd3
  } cmd_t;

endpackage

@@ hdl/energy_charge_meter_unit.sv @@
// ----------------------------------------------------------------------------
// energy_charge_meter_unit
// Multi-channel power meter with charge/energy accumulators and step counters.
// ----------------------------------------------------------------------------
// Channel  Dir  Width  Contents
// in_      in   40     cmd, channel, bus_raw, shunt_raw
// out_     out  144    voltage_mv, current_ma, power_mw, energy_count,
//                      charge_count, total_count
// cfg_     in   24     energy_threshold (0), charge_threshold (1)
//
// Per command: tick sweeps one channel per cycle through the shared adder, load
// makes three passes through the shared multiplier, then report; clear goes
// straight to report. in_tready returns with the result.
// One transaction in flight; in_tready only in idle.
// Result sits in an output register; the next item is taken while it waits.
// Synchronous active-low reset clears all but data regs; restores thresholds.
// ----------------------------------------------------------------------------
module energy_charge_meter_unit
  import ecm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [1:0] cmd, [3:2] channel, [19:4] bus_raw, [35:20] shunt_raw
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [15:0] voltage_mv, [27:16] current_ma, [45:28] power_mw,
  // [77:46] energy_count, [109:78] charge_count, [141:110] total_count
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_A_W-1:0]    cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_MUL_CUR,
    ST_MUL_PWR,
    ST_MUL_DIV,
    ST_PWR_WR,
    ST_REPORT
  } state_t;

  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

  state_t               state_r;
  logic [CH_W-1:0]      ch_r;
  logic [CH_W-1:0]      idx_r;
  logic [VOLT_W-1:0]    bus_r;
  logic [15:0]          shunt_r;
  logic [MUL_P_W-1:0]   mul_r;
  logic [ETHR_W-1:0]    ethr_r;
  logic [QTHR_W-1:0]    qthr_r;

  logic [VOLT_W-1:0]    volt_st  [CHANNELS];
  logic [CUR_W-1:0]     cur_st   [CHANNELS];
  logic [PWR_W-1:0]     pwr_st   [CHANNELS];
  logic [EACC_W-1:0]    eacc_st  [CHANNELS];
  logic [QACC_W-1:0]    qacc_st  [CHANNELS];
  logic [CNT_W-1:0]     ecnt_st  [CHANNELS];
  logic [CNT_W-1:0]     qcnt_st  [CHANNELS];
  logic [CNT_W-1:0]     total_r;

  logic                 out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  cmd_t                 in_cmd;
  logic [CH_W-1:0]      in_ch;
  logic                 in_ch_ok;
  logic                 ch_ok;
  logic                 in_fire;

  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [MUL_P_W-1:0]   mul_p;
  logic [CUR_W-1:0]     cur_val;

  logic [EACC_W-1:0]    e_sum;
  logic [QACC_W-1:0]    q_sum;
  logic                 e_hit;
  logic                 q_hit;

  logic [VOLT_W-1:0]    rep_volt;
  logic [CUR_W-1:0]     rep_cur;
  logic [PWR_W-1:0]     rep_pwr;
  logic [CNT_W-1:0]     rep_ecnt;
  logic [CNT_W-1:0]     rep_qcnt;

  assign in_cmd    = cmd_t'(in_tdata[1:0]);
  assign in_ch     = in_tdata[3:2];
  assign in_ch_ok  = (32'(in_ch) < CHANNELS);
  assign ch_ok     = (32'(ch_r) < CHANNELS);
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // shared multiplier
  assign cur_val = mul_r[CUR_SHIFT +: CUR_W];
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MUL_CUR: begin
        mul_a = MUL_A_W'(shunt_r);
        mul_b = MUL_B_W'(CUR_RECIP);
      end
      ST_MUL_PWR: begin
        mul_a = MUL_A_W'(bus_r);
        mul_b = MUL_B_W'(cur_val);
      end
      ST_MUL_DIV: begin
        mul_a = mul_r[MUL_A_W-1:0];
        mul_b = PWR_RECIP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

  // shared accumulate/compare unit
  assign e_sum = eacc_st[idx_r] + EACC_W'(pwr_st[idx_r]);
  assign q_sum = qacc_st[idx_r] + QACC_W'(cur_st[idx_r]);
  assign e_hit = (e_sum >= EACC_W'(ethr_r));
  assign q_hit = (q_sum >= QACC_W'(qthr_r));

  assign rep_volt = ch_ok ? volt_st[ch_r] : '0;
  assign rep_cur  = ch_ok ? cur_st[ch_r]  : '0;
  assign rep_pwr  = ch_ok ? pwr_st[ch_r]  : '0;
  assign rep_ecnt = ch_ok ? ecnt_st[ch_r] : '0;
  assign rep_qcnt = ch_ok ? qcnt_st[ch_r] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      ethr_r      <= ETHR_RESET;
      qthr_r      <= QTHR_RESET;
      total_r     <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        volt_st[i] <= '0;
        cur_st[i]  <= '0;
        pwr_st[i]  <= '0;
        eacc_st[i] <= '0;
        qacc_st[i] <= '0;
        ecnt_st[i] <= '0;
        qcnt_st[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_ENERGY_THR) begin
          ethr_r <= cfg_wdata[ETHR_W-1:0];
        end else if (cfg_addr == REG_CHARGE_THR) begin
          qthr_r <= cfg_wdata[QTHR_W-1:0];
        end
      end

      if (out_valid_r && out_tready && (state_r != ST_REPORT)) begin
        out_valid_r <= 1'b0;
      end

      mul_r <= mul_p;

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            ch_r    <= in_ch;
            idx_r   <= '0;
            bus_r   <= in_tdata[19:4];
            shunt_r <= in_tdata[35:20];
            unique case (in_cmd)
              CMD_TICK: state_r <= ST_TICK;
              CMD_LOAD: state_r <= in_ch_ok ? ST_MUL_CUR : ST_REPORT;
              CMD_CLR_CHAN: begin
                if (in_ch_ok) begin
                  eacc_st[in_ch] <= '0;
                  qacc_st[in_ch] <= '0;
                  ecnt_st[in_ch] <= '0;
                  qcnt_st[in_ch] <= '0;
                end
                state_r <= ST_REPORT;
              end
              CMD_CLR_TOTAL: begin
                total_r <= '0;
                state_r <= ST_REPORT;
              end
              default: state_r <= ST_REPORT;
            endcase
          end
        end
        ST_TICK: begin
          eacc_st[idx_r] <= e_hit ? '0 : e_sum;
          qacc_st[idx_r] <= q_hit ? '0 : q_sum;
          if (e_hit) begin
            ecnt_st[idx_r] <= ecnt_st[idx_r] + 1'b1;
            total_r        <= total_r + 1'b1;
          end
          if (q_hit) begin
            qcnt_st[idx_r] <= qcnt_st[idx_r] + 1'b1;
          end
          idx_r <= idx_r + 1'b1;
          if (idx_r == LAST_CH) begin
            state_r <= ST_REPORT;
          end
        end
        ST_MUL_CUR: state_r <= ST_MUL_PWR;
        ST_MUL_PWR: begin
          volt_st[ch_r] <= bus_r;
          cur_st[ch_r]  <= cur_val;
          state_r       <= ST_MUL_DIV;
        end
        ST_MUL_DIV: state_r <= ST_PWR_WR;
        ST_PWR_WR: begin
          pwr_st[ch_r] <= mul_r[PWR_SHIFT +: PWR_W];
          state_r      <= ST_REPORT;
        end
        ST_REPORT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {2'b00, total_r, rep_qcnt, rep_ecnt, rep_pwr, rep_cur, rep_volt};
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_tick_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TICK && idx_r == LAST_CH) |=> (state_r == ST_REPORT))
    else $error("tick sweep did not end after last channel");

  a_tick_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TICK) |-> (32'(idx_r) < CHANNELS))
    else $error("tick index out of range");

  a_load_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_cmd == CMD_LOAD && in_ch_ok) |=> (state_r == ST_MUL_CUR))
    else $error("load did not start multiplier sequence");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_REPORT))
    else $error("result raised outside report step");

endmodule

@@ bench/meter_checker.sv @@
// ----------------------------------------------------------------------------
// meter_checker
// Watches the input, result and register ports of the energy and charge
// meter. It keeps its own copy of the per-channel readings, accumulators,
// counters and thresholds, works out the report for each accepted input
// transaction and compares every accepted result with the oldest report
// still waiting.
// ----------------------------------------------------------------------------
module meter_checker
  import ecm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_A_W-1:0]    cfg_addr,
  input  logic [CFG_W-1:0]      cfg_wdata,
  output int                    fail_count,
  output int                    pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MA_DIVISOR = 20;
  localparam int unsigned MW_DIVISOR = 1000;

  typedef struct packed {
    logic [VOLT_W-1:0] voltage_mv;
    logic [CUR_W-1:0]  current_ma;
    logic [PWR_W-1:0]  power_mw;
    logic [CNT_W-1:0]  energy_count;
    logic [CNT_W-1:0]  charge_count;
    logic [CNT_W-1:0]  total_count;
  } meter_report_t;

  logic [ETHR_W-1:0] energy_thr;
  logic [QTHR_W-1:0] charge_thr;

  logic [VOLT_W-1:0] volt_mem   [CHANNELS];
  logic [CUR_W-1:0]  amp_mem    [CHANNELS];
  logic [PWR_W-1:0]  watt_mem   [CHANNELS];
  logic [EACC_W-1:0] energy_acc [CHANNELS];
  logic [QACC_W-1:0] charge_acc [CHANNELS];
  logic [CNT_W-1:0]  energy_cnt [CHANNELS];
  logic [CNT_W-1:0]  charge_cnt [CHANNELS];
  logic [CNT_W-1:0]  total_cnt;

  meter_report_t pending_reports[$];

  function automatic void meter_reset();
    energy_thr = ETHR_RESET;
    charge_thr = QTHR_RESET;
    for (int c = 0; c < CHANNELS; c++) begin
      volt_mem[c]   = '0;
      amp_mem[c]    = '0;
      watt_mem[c]   = '0;
      energy_acc[c] = '0;
      charge_acc[c] = '0;
      energy_cnt[c] = '0;
      charge_cnt[c] = '0;
    end
    total_cnt = '0;
  endfunction

  function automatic meter_report_t meter_step(cmd_t cmd, logic [CH_W-1:0] ch,
                                               logic [15:0] bus, logic [15:0] shunt);
    meter_report_t rep;
    logic          in_range;
    logic [EACC_W-1:0] e_sum;
    logic [QACC_W-1:0] q_sum;
    logic [15:0]   ma_full;
    logic [27:0]   prod;
    in_range = (ch < CHANNELS);
    case (cmd)
      CMD_TICK: begin
        for (int c = 0; c < CHANNELS; c++) begin
          e_sum = energy_acc[c] + watt_mem[c];
          q_sum = charge_acc[c] + amp_mem[c];
          if (e_sum >= energy_thr) begin
            e_sum = '0;
            energy_cnt[c] = energy_cnt[c] + 1;
            total_cnt = total_cnt + 1;
          end
          if (q_sum >= charge_thr) begin
            q_sum = '0;
            charge_cnt[c] = charge_cnt[c] + 1;
          end
          energy_acc[c] = e_sum;
          charge_acc[c] = q_sum;
        end
      end
      CMD_LOAD: begin
        if (in_range) begin
          ma_full = shunt / MA_DIVISOR;
          prod = {12'd0, bus} * {16'd0, ma_full[CUR_W-1:0]};
          volt_mem[ch] = bus;
          amp_mem[ch]  = ma_full[CUR_W-1:0];
          watt_mem[ch] = PWR_W'(prod / MW_DIVISOR);
        end
      end
      CMD_CLR_CHAN: begin
        if (in_range) begin
          energy_acc[ch] = '0;
          charge_acc[ch] = '0;
          energy_cnt[ch] = '0;
          charge_cnt[ch] = '0;
        end
      end
      default: total_cnt = '0;
    endcase
    rep = '0;
    if (in_range) begin
      rep.voltage_mv   = volt_mem[ch];
      rep.current_ma   = amp_mem[ch];
      rep.power_mw     = watt_mem[ch];
      rep.energy_count = energy_cnt[ch];
      rep.charge_count = charge_cnt[ch];
    end
    rep.total_count = total_cnt;
    return rep;
  endfunction

  function automatic void match(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    meter_report_t want;
    if (!rst_n) begin
      meter_reset();
      pending_reports.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_ENERGY_THR)
          energy_thr = cfg_wdata[ETHR_W-1:0];
        else if (cfg_addr == REG_CHARGE_THR)
          charge_thr = cfg_wdata[QTHR_W-1:0];
      end
      if (in_tvalid && in_tready)
        pending_reports.push_back(meter_step(cmd_t'(in_tdata[1:0]), in_tdata[3:2],
                                             in_tdata[19:4], in_tdata[35:20]));
      if (out_tvalid && out_tready) begin
        if (pending_reports.size() == 0) begin
          fail_count++;
          $display("%0t: result with none outstanding, actual %h", $time, out_tdata);
        end else begin
          want = pending_reports.pop_front();
          match("voltage_mv",   32'(want.voltage_mv), 32'(out_tdata[15:0]));
          match("current_ma",   32'(want.current_ma), 32'(out_tdata[27:16]));
          match("power_mw",     32'(want.power_mw),   32'(out_tdata[45:28]));
          match("energy_count", want.energy_count,    out_tdata[77:46]);
          match("charge_count", want.charge_count,    out_tdata[109:78]);
          match("total_count",  want.total_count,     out_tdata[141:110]);
        end
      end
    end
    pending_count <= pending_reports.size();
  end

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the energy and charge meter: a directed pass over the field
// extremes, every command, out-of-range channels and threshold corner cases,
// then random phases under several threshold settings with random gaps on
// both stream sides and long back-pressure stretches.
// ----------------------------------------------------------------------------
module tb_top;
  import ecm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_A_W-1:0]    cfg_addr = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  int                    fail_count;
  int                    pending_count;
  int                    src_burst = 0;

  always #10 clk = ~clk;

  energy_charge_meter_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  meter_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_item(cmd_t cmd, logic [CH_W-1:0] ch,
                                                     logic [15:0] bus, logic [15:0] shunt);
    return {4'd0, shunt, bus, ch, cmd};
  endfunction

  function automatic logic [15:0] draw_reading();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [IN_DATA_W-1:0] draw_item();
    int   r;
    cmd_t cmd;
    logic [CH_W-1:0] ch;
    r = $urandom_range(0, 99);
    if (r < 62)      cmd = CMD_TICK;
    else if (r < 88) cmd = CMD_LOAD;
    else if (r < 95) cmd = CMD_CLR_CHAN;
    else             cmd = CMD_CLR_TOTAL;
    ch = ($urandom_range(0, 9) == 0) ? 2'd3 : CH_W'($urandom_range(0, CHANNELS - 1));
    return pack_item(cmd, ch, draw_reading(), draw_reading());
  endfunction

  // in_tvalid is left high after the transaction; the next call lowers it only on a gap
  task automatic send(logic [IN_DATA_W-1:0] item);
    int gap;
    if (src_burst > 0) begin
      src_burst--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 49) == 0) src_burst = $urandom_range(20, 60);
      gap = draw_gap();
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= item;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_thresholds(logic [ETHR_W-1:0] e_thr, logic [QTHR_W-1:0] q_thr);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_ENERGY_THR;
    cfg_wdata <= e_thr;
    @(posedge clk);
    cfg_addr  <= REG_CHARGE_THR;
    cfg_wdata <= {{(CFG_W-QTHR_W){1'b0}}, q_thr};
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // result side: random stalls, ready stretches, two long hold-offs
  initial begin : sink
    int gap;
    int rounds;
    rounds = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      rounds++;
      if (rounds == 150 || rounds == 900) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      gap = draw_gap();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8))
        @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [ETHR_W-1:0] e_thr;
    logic [QTHR_W-1:0] q_thr;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset thresholds: extremes, out-of-range channel, every command
    send(pack_item(CMD_LOAD, 2'd0, 16'hFFFF, 16'hFFFF));
    send(pack_item(CMD_LOAD, 2'd1, 16'd0, 16'd0));
    send(pack_item(CMD_LOAD, 2'd2, 16'd12000, 16'd19));
    send(pack_item(CMD_LOAD, 2'd3, 16'd5000, 16'd4000));
    send(pack_item(CMD_TICK, 2'd0, 16'd0, 16'd0));
    send(pack_item(CMD_TICK, 2'd2, 16'hFFFF, 16'hFFFF));
    send(pack_item(CMD_CLR_CHAN, 2'd3, 16'd0, 16'd0));
    send(pack_item(CMD_CLR_CHAN, 2'd0, 16'd0, 16'd0));
    send(pack_item(CMD_CLR_TOTAL, 2'd1, 16'd0, 16'd0));
    send(pack_item(CMD_TICK, 2'd3, 16'd0, 16'd0));
    send(pack_item(CMD_CLR_TOTAL, 2'd3, 16'd0, 16'd0));

    // zero thresholds count on every tick
    set_thresholds('0, '0);
    send(pack_item(CMD_TICK, 2'd1, 16'd0, 16'd0));
    send(pack_item(CMD_TICK, 2'd2, 16'd0, 16'd0));

    // build up accumulators, then drop the thresholds below them
    set_thresholds('1, '1);
    send(pack_item(CMD_LOAD, 2'd0, 16'hFFFF, 16'hFFFF));
    repeat (4) send(pack_item(CMD_TICK, 2'd0, 16'd0, 16'd0));
    set_thresholds(24'd1000, 16'd1000);
    send(pack_item(CMD_TICK, 2'd0, 16'd0, 16'd0));
    send(pack_item(CMD_TICK, 2'd1, 16'd0, 16'd0));

    set_thresholds(24'd1, 16'd1);
    send(pack_item(CMD_LOAD, 2'd2, 16'd40000, 16'd50000));
    send(pack_item(CMD_TICK, 2'd2, 16'd0, 16'd0));

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin e_thr = ETHR_RESET; q_thr = QTHR_RESET; end
        1: begin e_thr = '1; q_thr = '1; end
        2: begin e_thr = 24'd1; q_thr = 16'd1; end
        3: begin
          e_thr = ETHR_W'($urandom_range(1, 400000));
          q_thr = QTHR_W'($urandom_range(1, 5000));
        end
        default: begin
          e_thr = ETHR_W'($urandom_range(1, 16777215));
          q_thr = QTHR_W'($urandom_range(1, 65535));
        end
      endcase
      set_thresholds(e_thr, q_thr);
      for (int n = 0; n < 315; n++) begin
        if (phase == 2 && n == 160) drain();
        send(draw_item());
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin : watchdog
    #30_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
